// File: design/sbsm_pkg.sv
`default_nettype none

package sbsm_pkg;

	// Access codes carried in the op field
	localparam logic [1:0] OP_CPU_RD = 2'd0;
	localparam logic [1:0] OP_CPU_WR = 2'd1;
	localparam logic [1:0] OP_PPU_RD = 2'd2;
	localparam logic [1:0] OP_PPU_WR = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANKS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_MIRROR  = 2'd2;

	// Serial load register targets, from CPU address bits 14:13
	localparam logic [1:0] SEL_CONTROL  = 2'd0;
	localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
	localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
	localparam logic [1:0] SEL_PRG      = 2'd3;

	// PRG banking modes, control bits 3:2
	localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

	localparam logic [4:0] CONTROL_RESET  = 5'h0C;
	localparam logic [4:0] PRG_MODE_BITS  = 5'h0C;
	localparam logic [2:0] MIRROR_FOUR    = 3'd4;
	localparam int         SHIFT_LOADS    = 5;

	// Pattern RAM is 8 KB, i.e. two 4 KB units
	localparam int         CHR_RAM_BYTES  = 8192;
	localparam int         CHR_UNIT_BYTES = 4096;
	localparam logic [5:0] CHR_RAM_UNITS  = 6'(CHR_RAM_BYTES / CHR_UNIT_BYTES);

	// Remainder unit sizes
	localparam int NUM_W  = 5;
	localparam int DEN_W  = 6;
	localparam int STEP_W = $clog2(NUM_W + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} rem_req_t;

	typedef struct packed {
		logic [4:0] prg_banks;
		logic [4:0] chr_banks;
		logic [2:0] hdr_mirror;
		logic [4:0] control;
		logic [4:0] chr_low;
		logic [4:0] chr_high;
		logic [3:0] prg_select;
		logic       control_written;
	} map_state_t;

	function automatic logic [2:0] mirror_of(map_state_t st);
		logic [2:0] m;
		if (st.control_written) begin
			m = {1'b0, st.control[1:0]};
		end else if (st.hdr_mirror > MIRROR_FOUR) begin
			m = MIRROR_FOUR;
		end else begin
			m = st.hdr_mirror;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// File: design/sbsm_ifs.sv
`default_nettype none

interface sbsm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] address;
	logic [7:0]  data;

	modport source (output valid, output op, output address, output data, input ready);
	modport sink (input valid, input op, input address, input data, output ready);
endinterface

interface sbsm_result_if;
	logic        valid;
	logic        ready;
	logic [17:0] mapped_offset;
	logic        target;
	logic        storage_write;
	logic        rejected;
	logic [2:0]  mirroring;

	modport source (output valid, output mapped_offset, output target, output storage_write,
		output rejected, output mirroring, input ready);
	modport sink (input valid, input mapped_offset, input target, input storage_write,
		input rejected, input mirroring, output ready);
endinterface

interface sbsm_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: design/serial_bank_switch_mapper.sv
// A CPU write or a rejected PPU write goes from ST_IDLE straight to ST_FIN;
// a CPU read, PPU read or pattern RAM write first waits in ST_RUN.
// ST_FIN loads the result register once it is free. A new item is taken only
// in ST_IDLE, after the 5 bit-steps of the shared remainder unit if needed.
// Reset: asynchronous, active low; all mapper and config registers take their
// documented values at once and the result register empties.
`default_nettype none

module serial_bank_switch_mapper import sbsm_pkg::*; #(
	parameter int MAX_PRG_BANKS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	sbsm_cfg_if.sink       cfg,
	sbsm_item_if.sink      item,
	sbsm_result_if.source  result
);

	localparam logic [4:0] MAX_BANKS = 5'(MAX_PRG_BANKS);

	state_t         state_q, state_d;
	map_state_t     mst;
	rem_req_t       req;
	logic           rem_done;
	logic [DEN_W-1:0] rem_val;

	logic           item_xfer;
	logic           out_load;
	logic           is_cpu_wr;
	logic           chr_ram;
	logic           needs_div;

	// Translation inputs for the remainder unit
	logic [4:0]     banks;
	logic [3:0]     prg_idx;
	logic [4:0]     chr_unit;
	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den;
	logic           is_chr;

	// Item context held while the remainder unit runs
	logic           is_chr_q;
	logic           zero_off_q;
	logic           wr_q;
	logic           rej_q;
	logic           tgt_q;
	logic [13:0]    low_q;

	// Result register
	logic           res_valid_q;
	logic [17:0]    res_offset_q;
	logic           res_target_q;
	logic           res_write_q;
	logic           res_rej_q;
	logic [2:0]     res_mirror_q;
	logic [17:0]    offset;

	assign cfg.ready = 1'b1;
	assign item_xfer = item.valid && item.ready;
	assign is_cpu_wr = (item.op == OP_CPU_WR);
	assign chr_ram   = (mst.chr_banks == '0);
	assign is_chr    = item.op[1];

	sbsm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_wdata (cfg.wdata),
		.cpu_we    (item_xfer && is_cpu_wr),
		.cpu_sel   (item.address[14:13]),
		.cpu_data  (item.data),
		.st        (mst)
	);

	// PRG bank pick: clamp the bank count, then apply the banking mode
	always_comb begin
		if (mst.prg_banks == '0) begin
			banks = 5'd1;
		end else if (mst.prg_banks > MAX_BANKS) begin
			banks = MAX_BANKS;
		end else begin
			banks = mst.prg_banks;
		end
		case (mst.control[3:2])
			PRG_MODE_FIX_FIRST: prg_idx = item.address[14] ? mst.prg_select : 4'd0;
			PRG_MODE_FIX_LAST:  prg_idx = item.address[14] ? 4'(banks - 5'd1)
			                                               : mst.prg_select;
			default:            prg_idx = {mst.prg_select[3:1], item.address[14]};
		endcase
	end

	// CHR unit pick in 4 KB steps: 8 KB mode forces the low bank even
	always_comb begin
		if (!mst.control[4]) begin
			chr_unit = {mst.chr_low[4:1], item.address[12]};
		end else if (item.address[12]) begin
			chr_unit = mst.chr_high;
		end else begin
			chr_unit = mst.chr_low;
		end
	end

	// The offset modulo storage size reduces to the bank index modulo the bank count
	always_comb begin
		if (is_chr) begin
			num = chr_unit;
			den = chr_ram ? CHR_RAM_UNITS : {mst.chr_banks, 1'b0};
		end else begin
			num = {1'b0, prg_idx};
			den = {1'b0, banks};
		end
	end

	assign needs_div = (item.op == OP_CPU_RD) || (item.op == OP_PPU_RD)
		|| ((item.op == OP_PPU_WR) && chr_ram);

	sbsm_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (rem_done),
		.rem    (rem_val)
	);

	// Sequencer: take an item, run the remainder unit if needed, then hand off
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		out_load   = 1'b0;
		req.start  = 1'b0;
		req.num    = num;
		req.den    = den;
		case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					if (needs_div) begin
						req.start = 1'b1;
						state_d   = ST_RUN;
					end else begin
						state_d   = ST_FIN;
					end
				end
			end
			ST_RUN: begin
				if (rem_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// Load the result register once its previous transfer is done
				if (!res_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the item context for the result
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			is_chr_q   <= is_chr;
			tgt_q      <= is_chr;
			low_q      <= item.address[13:0];
			zero_off_q <= !needs_div;
			wr_q       <= (item.op == OP_PPU_WR) && chr_ram;
			rej_q      <= (item.op == OP_PPU_WR) && !chr_ram;
		end
	end

	// Reassemble bank remainder and in-bank offset
	always_comb begin
		if (zero_off_q) begin
			offset = '0;
		end else if (is_chr_q) begin
			offset = {rem_val, low_q[11:0]};
		end else begin
			offset = {rem_val[3:0], low_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Mirroring is sampled after any CPU write of this item has landed
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_offset_q <= offset;
			res_target_q <= tgt_q;
			res_write_q  <= wr_q;
			res_rej_q    <= rej_q;
			res_mirror_q <= mirror_of(mst);
		end
	end

	assign result.valid         = res_valid_q;
	assign result.mapped_offset = res_offset_q;
	assign result.target        = res_target_q;
	assign result.storage_write = res_write_q;
	assign result.rejected      = res_rej_q;
	assign result.mirroring     = res_mirror_q;

	// The remainder unit finishes only while the sequencer waits on it
	a_rem_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> state_q == ST_RUN)
		else $error("remainder done outside run state");

	// A pattern RAM write always targets pattern storage and is never rejected
	a_write_target: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.storage_write |-> result.target && !result.rejected)
		else $error("storage write with bad target or reject");

	// A dropped write carries no offset
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.rejected |-> result.mapped_offset == '0)
		else $error("rejected write with nonzero offset");

	// No new item is taken while the sequencer is busy
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q != ST_IDLE)
		else $error("sequencer idle right after a transfer");

endmodule

`default_nettype wire

// File: design/sbsm_regs.sv
`default_nettype none

module sbsm_regs import sbsm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic                 cpu_we,
	input  wire logic [1:0]           cpu_sel,
	input  wire logic [7:0]           cpu_data,
	output map_state_t                st
);

	logic [4:0] prg_banks_q;
	logic [4:0] chr_banks_q;
	logic [2:0] hdr_mirror_q;
	logic [4:0] control_q;
	logic [4:0] chr_low_q;
	logic [4:0] chr_high_q;
	logic [3:0] prg_select_q;
	logic       control_written_q;
	logic [4:0] shift_q;
	logic [2:0] count_q;

	logic [4:0] shift_nx;
	logic [2:0] count_nx;

	// Serial load: add the data bit at the current position
	always_comb begin
		for (int i = 0; i < SHIFT_LOADS; i++) begin
			shift_nx[i] = shift_q[i] | (cpu_data[0] && (count_q == 3'(i)));
		end
		count_nx = count_q + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_banks_q       <= 5'd2;
			chr_banks_q       <= 5'd1;
			hdr_mirror_q      <= 3'd3;
			control_q         <= CONTROL_RESET;
			chr_low_q         <= '0;
			chr_high_q        <= '0;
			prg_select_q      <= '0;
			control_written_q <= 1'b0;
			shift_q           <= '0;
			count_q           <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRG_BANKS:  prg_banks_q  <= cfg_wdata[4:0];
					CFG_CHR_BANKS:  chr_banks_q  <= cfg_wdata[4:0];
					CFG_HDR_MIRROR: hdr_mirror_q <= cfg_wdata[2:0];
					default: ;
				endcase
			end
			if (cpu_we) begin
				if (cpu_data[7]) begin
					shift_q   <= '0;
					count_q   <= '0;
					control_q <= control_q | PRG_MODE_BITS;
				end else if (count_nx >= 3'(SHIFT_LOADS)) begin
					case (cpu_sel)
						SEL_CONTROL: begin
							control_q         <= shift_nx;
							control_written_q <= 1'b1;
						end
						SEL_CHR_LOW:  chr_low_q    <= shift_nx;
						SEL_CHR_HIGH: chr_high_q   <= shift_nx;
						SEL_PRG:      prg_select_q <= shift_nx[3:0];
						default: ;
					endcase
					shift_q <= '0;
					count_q <= '0;
				end else begin
					shift_q <= shift_nx;
					count_q <= count_nx;
				end
			end
		end
	end

	always_comb begin
		st.prg_banks       = prg_banks_q;
		st.chr_banks       = chr_banks_q;
		st.hdr_mirror      = hdr_mirror_q;
		st.control         = control_q;
		st.chr_low         = chr_low_q;
		st.chr_high        = chr_high_q;
		st.prg_select      = prg_select_q;
		st.control_written = control_written_q;
	end

endmodule

`default_nettype wire

// File: design/sbsm_rem.sv
`default_nettype none

module sbsm_rem import sbsm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rem_req_t         req,
	output logic                  done,
	output logic [DEN_W-1:0]      rem
);

	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W-1:0]  rem_nx;

	// One restoring step: shift in the next numerator bit, subtract if it fits
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		if (trial >= {1'b0, den_q}) begin
			rem_nx = DEN_W'(trial - {1'b0, den_q});
		end else begin
			rem_nx = trial[DEN_W-1:0];
		end
	end

	assign done = (cnt_q == STEP_W'(1));
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= STEP_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

endmodule

`default_nettype wire

// File: dv/sbsm_checker.sv
`default_nettype none

module sbsm_checker import sbsm_pkg::*; #(
	parameter int MAX_PRG_BANKS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sbsm_cfg_if         cfg,
	sbsm_item_if        item,
	sbsm_result_if      result,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PRG_BANK_BYTES = 16384;
	localparam int          CHR_BANK_BYTES = 8192;
	localparam int          PRINT_LIMIT    = 40;
	localparam logic [4:0]  PRG_BANKS_INIT = 5'd2;
	localparam logic [4:0]  CHR_BANKS_INIT = 5'd1;
	localparam logic [2:0]  MIRROR_INIT    = 3'd3;

	typedef struct packed {
		logic [17:0] mapped_offset;
		logic        target;
		logic        storage_write;
		logic        rejected;
		logic [2:0]  mirroring;
	} access_result_t;

	// configuration copy
	logic [4:0] prg_banks_q;
	logic [4:0] chr_banks_q;
	logic [2:0] hdr_mirror_q;

	// mapper registers
	logic [4:0] shift_q;
	logic [2:0] loads_q;
	logic [4:0] control_q;
	logic [4:0] chr_lo_q;
	logic [4:0] chr_hi_q;
	logic [3:0] prg_sel_q;
	logic       control_loaded_q;

	access_result_t pending_results[$];

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT) begin
			$display("%0t ns checker: %s", $realtime, msg);
		end
	endtask

	function automatic logic [2:0] live_mirroring();
		logic [2:0] m;
		if (control_loaded_q) begin
			m = {1'b0, control_q[1:0]};
		end else begin
			m = (hdr_mirror_q > MIRROR_FOUR) ? MIRROR_FOUR : hdr_mirror_q;
		end
		return m;
	endfunction

	function automatic int unsigned prg_byte_offset(logic [15:0] addr);
		int unsigned banks;
		int unsigned bank;
		if (prg_banks_q == 0) begin
			banks = 1;
		end else if (prg_banks_q > MAX_PRG_BANKS) begin
			banks = MAX_PRG_BANKS;
		end else begin
			banks = prg_banks_q;
		end
		case (control_q[3:2])
			PRG_MODE_FIX_FIRST: bank = addr[14] ? prg_sel_q : 0;
			PRG_MODE_FIX_LAST: bank = addr[14] ? banks - 1 : prg_sel_q;
			default: bank = {prg_sel_q[3:1], addr[14]};
		endcase
		return (bank * PRG_BANK_BYTES + addr[13:0]) % (banks * PRG_BANK_BYTES);
	endfunction

	function automatic int unsigned chr_byte_offset(logic [15:0] addr);
		int unsigned a;
		int unsigned off;
		int unsigned span;
		a = addr[12:0];
		span = (chr_banks_q == 0) ? CHR_RAM_BYTES : chr_banks_q * CHR_BANK_BYTES;
		if (!control_q[4]) begin
			off = {chr_lo_q[4:1], 1'b0} * CHR_UNIT_BYTES + a;
		end else if (a < CHR_UNIT_BYTES) begin
			off = chr_lo_q * CHR_UNIT_BYTES + a;
		end else begin
			off = chr_hi_q * CHR_UNIT_BYTES + (a - CHR_UNIT_BYTES);
		end
		return off % span;
	endfunction

	// serial port: LSB first, bit 7 clears, fifth bit commits
	function automatic void serial_write(logic [15:0] addr, logic [7:0] data);
		logic [4:0] loaded;
		loaded = shift_q | (5'(data[0]) << loads_q);
		if (data[7]) begin
			shift_q = '0;
			loads_q = '0;
			control_q = control_q | PRG_MODE_BITS;
		end else if (loads_q + 1 < SHIFT_LOADS) begin
			shift_q = loaded;
			loads_q = loads_q + 3'd1;
		end else begin
			case (addr[14:13])
				SEL_CONTROL: begin
					control_q = loaded;
					control_loaded_q = 1'b1;
				end
				SEL_CHR_LOW: chr_lo_q = loaded;
				SEL_CHR_HIGH: chr_hi_q = loaded;
				SEL_PRG: prg_sel_q = loaded[3:0];
			endcase
			shift_q = '0;
			loads_q = '0;
		end
	endfunction

	function automatic access_result_t predict_access(logic [1:0] op, logic [15:0] addr,
			logic [7:0] data);
		access_result_t r;
		r = '0;
		case (op)
			OP_CPU_RD: r.mapped_offset = 18'(prg_byte_offset(addr));
			OP_CPU_WR: serial_write(addr, data);
			OP_PPU_RD: begin
				r.target = 1'b1;
				r.mapped_offset = 18'(chr_byte_offset(addr));
			end
			OP_PPU_WR: begin
				r.target = 1'b1;
				if (chr_banks_q == 0) begin
					r.mapped_offset = 18'(chr_byte_offset(addr));
					r.storage_write = 1'b1;
				end else begin
					r.rejected = 1'b1;
				end
			end
		endcase
		r.mirroring = live_mirroring();
		return r;
	endfunction

	// order per edge: config, then result, then new access
	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		if (!arst_n) begin
			prg_banks_q = PRG_BANKS_INIT;
			chr_banks_q = CHR_BANKS_INIT;
			hdr_mirror_q = MIRROR_INIT;
			shift_q = '0;
			loads_q = '0;
			control_q = CONTROL_RESET;
			chr_lo_q = '0;
			chr_hi_q = '0;
			prg_sel_q = '0;
			control_loaded_q = 1'b0;
			pending_results.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_PRG_BANKS: prg_banks_q = cfg.wdata[4:0];
					CFG_CHR_BANKS: chr_banks_q = cfg.wdata[4:0];
					CFG_HDR_MIRROR: hdr_mirror_q = cfg.wdata[2:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected, offset %0h",
						result.mapped_offset));
				end else begin
					want = pending_results.pop_front();
					if (result.mapped_offset !== want.mapped_offset)
						report_mismatch($sformatf("mapped_offset got %0h expected %0h",
							result.mapped_offset, want.mapped_offset));
					if (result.target !== want.target)
						report_mismatch($sformatf("target got %0b expected %0b",
							result.target, want.target));
					if (result.storage_write !== want.storage_write)
						report_mismatch($sformatf("storage_write got %0b expected %0b",
							result.storage_write, want.storage_write));
					if (result.rejected !== want.rejected)
						report_mismatch($sformatf("rejected got %0b expected %0b",
							result.rejected, want.rejected));
					if (result.mirroring !== want.mirroring)
						report_mismatch($sformatf("mirroring got %0d expected %0d",
							result.mirroring, want.mirroring));
				end
			end
			if (item.valid && item.ready) begin
				pending_results.push_back(predict_access(item.op, item.address, item.data));
			end
			outstanding = pending_results.size();
		end
	end

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbsm_pkg::*;

	// index with no register behind it; writes to it must be ignored
	localparam logic [1:0] CFG_UNUSED   = 2'd3;
	localparam int         DRAIN_CYCLES = 12;
	localparam int         LONG_HOLD    = 300;
	localparam int         PHASES       = 8;
	localparam int         PHASE_ITEMS  = 116;

	typedef enum {
		STALL_NONE,
		STALL_COIN,
		STALL_SPARSE,
		STALL_PERIODIC
	} stall_style_t;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned outstanding;

	// sender state: burst bookkeeping and the gap ceiling of the current phase
	int unsigned burst_left;
	int unsigned max_gap;
	int unsigned accesses_sent;
	bit          long_hold_req;

	sbsm_cfg_if    cfg_bus();
	sbsm_item_if   item_bus();
	sbsm_result_if res_bus();

	serial_bank_switch_mapper #(
		.MAX_PRG_BANKS(16)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.item   (item_bus),
		.result (res_bus)
	);

	sbsm_checker #(
		.MAX_PRG_BANKS(16)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_bus),
		.item        (item_bus),
		.result      (res_bus),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run, long holds included.
	initial begin
		#5000000;
		$display("serial_bank_switch_mapper: mismatch");
		$finish;
	end

	// Offer one access and hold it until the transfer. Between bursts, drop
	// valid for a random gap so that idle cycles land on every step of the
	// block's work.
	task automatic send_access(input logic [1:0] op, input logic [15:0] addr,
			input logic [7:0] data);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (max_gap != 0) begin
				item_bus.valid <= 1'b0;
				repeat ($urandom_range(1, max_gap)) @(posedge clk);
			end
		end
		burst_left--;
		item_bus.valid   <= 1'b1;
		item_bus.op      <= op;
		item_bus.address <= addr;
		item_bus.data    <= data;
		do @(posedge clk); while (!item_bus.ready);
		accesses_sent++;
	endtask

	// Five CPU writes that shift value in LSB first; only the last address
	// picks the register, the others carry random noise.
	task automatic load_serial(input logic [15:0] last_addr, input logic [4:0] value);
		int k;
		for (k = 0; k < SHIFT_LOADS; k++) begin
			send_access(OP_CPU_WR, (k == SHIFT_LOADS - 1) ? last_addr : 16'($urandom),
				{1'b0, 6'($urandom), value[k]});
		end
	endtask

	// Write all three registers plus the unused index. Upper data bits are
	// random: the block must drop them. Valid stays high across the writes.
	task automatic program_mapper(input logic [4:0] prg, input logic [4:0] chr,
			input logic [2:0] mirror);
		logic [1:0] idx[4];
		logic [7:0] vals[4];
		int i;
		idx = '{CFG_PRG_BANKS, CFG_CHR_BANKS, CFG_HDR_MIRROR, CFG_UNUSED};
		vals = '{{3'($urandom), prg}, {3'($urandom), chr}, {5'($urandom), mirror},
			8'($urandom)};
		for (i = 0; i < 4; i++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx[i];
			cfg_bus.wdata <= vals[i];
			do @(posedge clk); while (!cfg_bus.ready);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	// Drop valid, wait for every expected result, then let the pipe settle.
	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random traffic. Mostly complete serial loads mixed with reads, so the
	// bank registers keep moving; the rest is pattern writes, aborted loads and raw noise.
	task automatic run_random(input int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned n;
		int unsigned k;
		logic [15:0] addr;
		stop_at = accesses_sent + count;
		while (accesses_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				load_serial(16'($urandom), 5'($urandom));
			end else if (pick < 38) begin
				// partial load, then a clearing write
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++) begin
					send_access(OP_CPU_WR, 16'($urandom), {1'b0, 7'($urandom)});
				end
				send_access(OP_CPU_WR, 16'($urandom), 8'($urandom) | 8'h80);
			end else if (pick < 65) begin
				addr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : {1'b1, 15'($urandom)};
				send_access(OP_CPU_RD, addr, 8'($urandom));
			end else if (pick < 88) begin
				addr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : {3'b000, 13'($urandom)};
				send_access(OP_PPU_RD, addr, 8'($urandom));
			end else if (pick < 96) begin
				addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {3'b000, 13'($urandom)};
				send_access(OP_PPU_WR, addr, 8'($urandom));
			end else begin
				send_access(2'($urandom), 16'($urandom), 8'($urandom));
			end
		end
	endtask

	// Result side: segments of random length, each with its own stall style.
	// A long hold, when requested, keeps ready low while the sender keeps
	// offering, so the block backs up and stalls its input.
	initial begin : receiver
		int unsigned span;
		int unsigned n;
		stall_style_t style;
		res_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				res_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				span = $urandom_range(10, 80);
				style = stall_style_t'($urandom_range(0, 3));
				for (n = 0; n < span; n++) begin
					case (style)
						STALL_NONE: res_bus.ready <= 1'b1;
						STALL_COIN: res_bus.ready <= 1'($urandom_range(0, 1));
						STALL_SPARSE: res_bus.ready <= ($urandom_range(0, 4) == 0);
						STALL_PERIODIC: res_bus.ready <= (n % 4 == 3);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int phase;
		burst_left = 0;
		max_gap = 3;
		accesses_sent = 0;
		long_hold_req = 1'b0;
		arst_n <= 1'b0;
		item_bus.valid <= 1'b0;
		item_bus.op <= OP_CPU_RD;
		item_bus.address <= '0;
		item_bus.data <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= CFG_PRG_BANKS;
		cfg_bus.wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset settings: two PRG banks, one CHR ROM
		// bank, horizontal mirroring, last bank fixed at 0xC000.
		send_access(OP_CPU_RD, 16'h8000, 8'h00);
		send_access(OP_CPU_RD, 16'hFFFF, 8'hFF);
		// bit 15 clear still decodes like 0x8000
		send_access(OP_CPU_RD, 16'h0000, 8'h00);
		send_access(OP_PPU_RD, 16'h0000, 8'h00);
		// PPU side ignores bits above 12
		send_access(OP_PPU_RD, 16'hFFFF, 8'hFF);
		// write to pattern ROM: dropped
		send_access(OP_PPU_WR, 16'h1FFF, 8'hA5);
		// PRG register keeps only four bits of 0x1F
		load_serial(16'hE000, 5'h1F);
		send_access(OP_CPU_RD, 16'hC000, 8'h00);
		send_access(OP_CPU_RD, 16'hBFFF, 8'h00);
		// start a load, then clear it with bit 7
		send_access(OP_CPU_WR, 16'h8000, 8'h01);
		send_access(OP_CPU_WR, 16'h9FFF, 8'h80);
		// control: 32 KB PRG, 4 KB CHR, vertical mirroring
		load_serial(16'h9FFF, 5'h12);
		send_access(OP_PPU_RD, 16'h1000, 8'h00);
		send_access(OP_CPU_RD, 16'hDFFF, 8'h00);
		send_access(OP_PPU_WR, 16'h0FFF, 8'h3C);

		// Random phases, each on fresh settings written while idle. The
		// first few hit the extremes: one bank with pattern RAM, the
		// maximum bank counts, and values past the top that get clamped.
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: program_mapper(5'd1, 5'd0, 3'd0);
				1: program_mapper(5'd16, 5'd16, 3'd4);
				2: program_mapper(5'd0, 5'd31, 3'd7);
				3: program_mapper(5'd20, 5'd0, 3'd5);
				4: program_mapper(5'd8, 5'd3, 3'd1);
				default: program_mapper(5'($urandom), 5'($urandom), 3'($urandom));
			endcase
			max_gap = (phase % 3 == 2) ? 0 : $urandom_range(2, 8);
			if (phase == 1 || phase == 5) long_hold_req = 1'b1;
			run_random(PHASE_ITEMS);
		end

		wait_idle();
		if (fail_count == 0 && outstanding == 0) begin
			$display("serial_bank_switch_mapper: match");
		end else begin
			$display("serial_bank_switch_mapper: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
